FILE: design/hvd_pkg.sv
// Shared types, constants and tables for the haversine distance pipeline.
// No dependencies; every other design file refers to this package by scoped names.
package hvd_pkg;

  // Number of CORDIC iterations in each rotation and vectoring pass (12 to 32).
  localparam int CORDIC_STEPS = 24;

  // Angle lanes: half of dlat, half of dlon, first latitude, second latitude.
  localparam int LANES     = 4;
  localparam int LANE_DLAT = 0;
  localparam int LANE_DLON = 1;
  localparam int LANE_LAT1 = 2;
  localparam int LANE_LAT2 = 3;

  // Field widths.
  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int DLON_W   = LON_W + 1;
  localparam int DLAT_W   = LAT_W + 1;
  localparam int MAG_W    = 28;
  localparam int RADIUS_W = 23;
  localparam int DIST_W   = 31;
  localparam int R200_W   = 31;

  // Microdegree limits.
  localparam logic signed [LAT_W-1:0]  UDEG_90  = 28'sd90000000;
  localparam logic signed [DLON_W-1:0] UDEG_180 = 30'sd180000000;
  localparam logic signed [DLON_W-1:0] UDEG_360 = 30'sd360000000;

  // Degree to radian conversion: round(mag * pi * 2^32 / divisor).
  localparam int PI_SPLIT = 17;
  localparam logic [33:0] PI_Q32 = 34'd13493037705;
  localparam logic [PI_SPLIT-1:0] PI_HI = PI_Q32[33:PI_SPLIT];
  localparam logic [PI_SPLIT-1:0] PI_LO = PI_Q32[PI_SPLIT-1:0];
  localparam int MUL_W = MAG_W + PI_SPLIT;
  localparam logic [63:0] DIV_WHOLE = 64'd720000000;
  localparam logic [63:0] DIV_HALF  = 64'd1440000000;
  localparam int QUO_BITS = 31;

  // Each divisor is an odd factor times a power of two. The power of two is a
  // shift; the odd factor is divided by a reciprocal multiply on the top 32 bits
  // of the shifted dividend, which undershoots by at most two, then corrected.
  localparam int SHIFT_WHOLE = 10;
  localparam int SHIFT_HALF  = 11;
  localparam int Y_W   = 51;
  localparam int REM_W = 24;
  localparam logic [REM_W-1:0] DIV_ODD  = 24'd703125;
  localparam logic [REM_W-1:0] DIV_ODD2 = 24'd1406250;
  localparam logic [31:0]      RECIP    = 32'd3202559735;

  // Q2.30 fixed-point constants.
  localparam int CW = 34;
  localparam int Q_W = 31;
  localparam int PROD_W = 2 * Q_W;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [Q_W-1:0] ONE_Q30     = 31'd1073741824;
  localparam logic [Q_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [PROD_W-1:0] HALF_LSB = 62'd536870912;
  localparam int ROOT_BITS = 31;

  // Radius register.
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd6371000;
  localparam logic [R200_W-1:0]   R200_RESET   = 31'd1274200000;
  localparam logic [R200_W-1:0]   R200_SCALE   = 31'd200;
  localparam logic [DIST_W-1:0]   DIST_MAX     = 31'h7FFFFFFF;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  // Registered stages in the back end.
  localparam int BACK_DEPTH = 48 + 2 * CORDIC_STEPS;

  // One classified pair: sign and magnitude of each angle in microdegrees.
  typedef struct packed {
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][MAG_W-1:0] mag;
  } angle_set_t;

  // Queue status seen by the producer and the consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_flags_t;

  // Arctangent of 2^-idx in Q2.30.
  function automatic logic signed [CW-1:0] atan_entry(input int idx);
    logic signed [CW-1:0] v;
    case (idx)
      0:  v = 34'sh03243F6A8;
      1:  v = 34'sh01DAC6705;
      2:  v = 34'sh00FADBAFC;
      3:  v = 34'sh007F56EA6;
      4:  v = 34'sh003FEAB76;
      5:  v = 34'sh001FFD55B;
      6:  v = 34'sh000FFFAAA;
      7:  v = 34'sh0007FFF55;
      8:  v = 34'sh0003FFFEA;
      9:  v = 34'sh0001FFFFD;
      10: v = 34'sh0000FFFFF;
      11: v = 34'sh00007FFFF;
      12: v = 34'sh00003FFFF;
      13: v = 34'sh00001FFFF;
      14: v = 34'sh00000FFFF;
      15: v = 34'sh000007FFF;
      16: v = 34'sh000003FFF;
      17: v = 34'sh000001FFF;
      18: v = 34'sh000000FFF;
      19: v = 34'sh0000007FF;
      20: v = 34'sh0000003FF;
      21: v = 34'sh0000001FF;
      22: v = 34'sh0000000FF;
      23: v = 34'sh00000007F;
      24: v = 34'sh00000003F;
      25: v = 34'sh00000001F;
      26: v = 34'sh00000000F;
      27: v = 34'sh000000008;
      28: v = 34'sh000000004;
      29: v = 34'sh000000002;
      30: v = 34'sh000000001;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Half angles divide by twice the whole-angle divisor.
  function automatic logic [63:0] lane_divisor(input int lane);
    return (lane == LANE_DLAT || lane == LANE_DLON) ? DIV_HALF : DIV_WHOLE;
  endfunction

  // Power-of-two part of each lane's divisor.
  function automatic int lane_shift(input int lane);
    return (lane == LANE_DLAT || lane == LANE_DLON) ? SHIFT_HALF : SHIFT_WHOLE;
  endfunction

endpackage

FILE: design/hvd_front.sv
// Front end: accepts point pairs, clamps latitudes, reduces the longitude
// difference and hands sign/magnitude angles to the queue. Uses hvd_pkg.
module hvd_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hvd_pkg::LAT_W-1:0]    first_latitude,
  input  logic signed [hvd_pkg::LAT_W-1:0]    second_latitude,
  input  logic signed [hvd_pkg::LON_W-1:0]    first_longitude,
  input  logic signed [hvd_pkg::LON_W-1:0]    second_longitude,
  input  hvd_pkg::queue_flags_t               flags,
  output logic                                push,
  output hvd_pkg::angle_set_t                 item
);

  logic v1;
  logic v2;
  logic fadv;
  logic signed [hvd_pkg::LAT_W-1:0]  lat1c;
  logic signed [hvd_pkg::LAT_W-1:0]  lat2c;
  logic signed [hvd_pkg::DLON_W-1:0] dlon_raw;
  logic signed [hvd_pkg::DLAT_W-1:0] dlat;
  logic signed [hvd_pkg::DLON_W-1:0] dlon;

  function automatic logic signed [hvd_pkg::LAT_W-1:0] clamp_lat(
    input logic signed [hvd_pkg::LAT_W-1:0] x);
    if (x > hvd_pkg::UDEG_90) begin
      return hvd_pkg::UDEG_90;
    end else if (x < -hvd_pkg::UDEG_90) begin
      return -hvd_pkg::UDEG_90;
    end
    return x;
  endfunction

  function automatic logic [hvd_pkg::MAG_W-1:0] mag_of(
    input logic signed [hvd_pkg::DLON_W-1:0] x);
    logic signed [hvd_pkg::DLON_W-1:0] a;
    a = (x < 0) ? -x : x;
    return a[hvd_pkg::MAG_W-1:0];
  endfunction

  // The front moves unless its last stage holds an item the queue cannot take.
  assign fadv     = !v2 || !flags.full;
  assign in_stall = !fadv;
  assign push     = v2 && !flags.full;

  // Latitude difference, and longitude difference folded into [-180, 180] degrees.
  always_comb begin
    dlat = hvd_pkg::DLAT_W'(lat2c) - hvd_pkg::DLAT_W'(lat1c);
    if (dlon_raw > hvd_pkg::UDEG_180) begin
      dlon = dlon_raw - hvd_pkg::UDEG_360;
    end else if (dlon_raw < -hvd_pkg::UDEG_180) begin
      dlon = dlon_raw + hvd_pkg::UDEG_360;
    end else begin
      dlon = dlon_raw;
    end
  end

  // Valid bits of the two front stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (fadv) begin
      v1 <= in_valid;
      v2 <= v1;
    end
  end

  // Stage one clamps latitudes and subtracts longitudes; stage two classifies each angle.
  always_ff @(posedge clk) begin
    if (fadv) begin
      lat1c    <= clamp_lat(first_latitude);
      lat2c    <= clamp_lat(second_latitude);
      dlon_raw <= hvd_pkg::DLON_W'(second_longitude) - hvd_pkg::DLON_W'(first_longitude);
      item.neg[hvd_pkg::LANE_DLAT] <= dlat < 0;
      item.neg[hvd_pkg::LANE_DLON] <= dlon < 0;
      item.neg[hvd_pkg::LANE_LAT1] <= lat1c < 0;
      item.neg[hvd_pkg::LANE_LAT2] <= lat2c < 0;
      item.mag[hvd_pkg::LANE_DLAT] <= mag_of(hvd_pkg::DLON_W'(dlat));
      item.mag[hvd_pkg::LANE_DLON] <= mag_of(dlon);
      item.mag[hvd_pkg::LANE_LAT1] <= mag_of(hvd_pkg::DLON_W'(lat1c));
      item.mag[hvd_pkg::LANE_LAT2] <= mag_of(hvd_pkg::DLON_W'(lat2c));
    end
  end

endmodule

FILE: design/hvd_queue.sv
// Short queue that decouples the front end from the back-end pipeline.
// Uses hvd_pkg for the item type, the flag struct and the depth.
module hvd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  hvd_pkg::angle_set_t   item_in,
  input  logic                  pop,
  output hvd_pkg::angle_set_t   head,
  output hvd_pkg::queue_flags_t flags
);

  hvd_pkg::angle_set_t mem [hvd_pkg::QUEUE_DEPTH];
  logic [hvd_pkg::QPTR_W-1:0] wr_ptr;
  logic [hvd_pkg::QPTR_W-1:0] rd_ptr;
  logic [hvd_pkg::QPTR_W:0]   count;

  assign flags.full  = count == (hvd_pkg::QPTR_W + 1)'(hvd_pkg::QUEUE_DEPTH);
  assign flags.empty = count == '0;
  assign head        = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !flags.full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !flags.empty)
    else $error("queue read while empty");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> !flags.empty)
    else $error("queue empty after a lone write");

endmodule

FILE: design/hvd_back.sv
// Back end: degree-to-radian conversion, CORDIC sine/cosine, haversine term,
// square roots, CORDIC atan2 and radius scaling in one stallable pipeline. Uses hvd_pkg.
module hvd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  hvd_pkg::angle_set_t               head,
  input  hvd_pkg::queue_flags_t             flags,
  output logic                              pop,
  input  logic [hvd_pkg::R200_W-1:0]        radius_x200,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [hvd_pkg::DIST_W-1:0]        distance_cm
);

  localparam int N  = hvd_pkg::CORDIC_STEPS;
  localparam int L  = hvd_pkg::LANES;
  localparam int CW = hvd_pkg::CW;
  localparam int QW = hvd_pkg::Q_W;
  localparam int PW = hvd_pkg::PROD_W;
  localparam int QB = hvd_pkg::QUO_BITS;
  localparam int RB = hvd_pkg::ROOT_BITS;

  logic [hvd_pkg::BACK_DEPTH-1:0] vld;
  logic adv;

  // Conversion multiply, shift, reciprocal estimate and correction.
  logic [hvd_pkg::MUL_W-1:0] m_hi [L];
  logic [hvd_pkg::MUL_W-1:0] m_lo [L];
  logic [L-1:0]              m_neg;
  logic [hvd_pkg::Y_W-1:0]   x_y   [L];
  logic [L-1:0]              x_neg;
  logic [QB-1:0]             e_q   [L];
  logic [hvd_pkg::REM_W-1:0] e_ylo [L];
  logic [L-1:0]              e_neg;
  logic [QB-1:0]             r_q   [L];
  logic [hvd_pkg::REM_W-1:0] r_rem [L];
  logic [L-1:0]              r_neg;
  logic [QB-1:0]             c_q   [L];
  logic [L-1:0]              c_neg;

  // Rotation CORDIC.
  logic signed [CW-1:0] cx [L][N+1];
  logic signed [CW-1:0] cy [L][N+1];
  logic signed [CW-1:0] cz [L][N+1];

  // Haversine term.
  logic [QW-1:0] k_cos1, k_cos2, k_sin1, k_sin2;
  logic [PW-1:0] p_cc, p_s1, p_s2, p_t;
  logic [QW-1:0] r_cc, r_s1, r_s2, h_s1, h2_s1, r_t;
  logic [QW-1:0] hav_a;

  // Square roots: index 0 is sqrt(a), index 1 is sqrt(1 - a).
  logic [63:0]   s_rem  [2][RB+1];
  logic [RB-1:0] s_root [2][RB+1];

  // Vectoring CORDIC and scaling.
  logic signed [CW-1:0] vx [N+1];
  logic signed [CW-1:0] vy [N+1];
  logic signed [CW-1:0] vz [N+1];
  logic [QW-1:0] theta;
  logic [PW-1:0] f_prod;
  logic [PW:0]   f_sum;

  function automatic logic [QW-1:0] round_q30(input logic [PW-1:0] p);
    logic [PW-1:0] t;
    t = p + hvd_pkg::HALF_LSB;
    return t[60:30];
  endfunction

  function automatic logic [QW-1:0] clamp_cos(input logic signed [CW-1:0] x);
    if (x < 0) begin
      return '0;
    end else if (x > $signed(CW'(hvd_pkg::ONE_Q30))) begin
      return hvd_pkg::ONE_Q30;
    end
    return x[QW-1:0];
  endfunction

  function automatic logic [QW-1:0] abs_sin(input logic signed [CW-1:0] y);
    logic signed [CW-1:0] a;
    a = (y < 0) ? -y : y;
    if (a > $signed(CW'(hvd_pkg::ONE_Q30))) begin
      return hvd_pkg::ONE_Q30;
    end
    return a[QW-1:0];
  endfunction

  // The whole pipeline moves together unless a finished result is held.
  assign adv         = !vld[hvd_pkg::BACK_DEPTH-1] || !out_stall;
  assign pop         = adv && !flags.empty;
  assign out_valid   = vld[hvd_pkg::BACK_DEPTH-1];
  assign f_sum       = (PW + 1)'(f_prod) + (PW + 1)'(hvd_pkg::HALF_LSB);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[hvd_pkg::BACK_DEPTH-2:0], pop};
    end
  end

  // Degrees to Q30 radians in five stages: split product, rounding offset and
  // power-of-two shift, reciprocal estimate, remainder, then up to two corrections.
  always_ff @(posedge clk) begin
    if (adv) begin
      m_neg <= head.neg;
      x_neg <= m_neg;
      e_neg <= x_neg;
      r_neg <= e_neg;
      c_neg <= r_neg;
      for (int l = 0; l < L; l++) begin
        m_hi[l] <= hvd_pkg::MUL_W'(head.mag[l]) * hvd_pkg::MUL_W'(hvd_pkg::PI_HI);
        m_lo[l] <= hvd_pkg::MUL_W'(head.mag[l]) * hvd_pkg::MUL_W'(hvd_pkg::PI_LO);
        x_y[l] <= hvd_pkg::Y_W'(((64'(m_hi[l]) << hvd_pkg::PI_SPLIT) + 64'(m_lo[l])
                  + (hvd_pkg::lane_divisor(l) >> 1)) >> hvd_pkg::lane_shift(l));
        e_q[l] <= QB'((64'(x_y[l][hvd_pkg::Y_W-1:hvd_pkg::Y_W-32])
                  * 64'(hvd_pkg::RECIP)) >> 32);
        e_ylo[l] <= x_y[l][hvd_pkg::REM_W-1:0];
        r_q[l] <= e_q[l];
        r_rem[l] <= e_ylo[l] - hvd_pkg::REM_W'(e_q[l] * hvd_pkg::DIV_ODD);
        if (r_rem[l] >= hvd_pkg::DIV_ODD2) begin
          c_q[l] <= r_q[l] + QB'(2);
        end else if (r_rem[l] >= hvd_pkg::DIV_ODD) begin
          c_q[l] <= r_q[l] + QB'(1);
        end else begin
          c_q[l] <= r_q[l];
        end
      end
    end
  end

  // Rotation CORDIC, one iteration per stage, four lanes side by side.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < L; l++) begin
        cx[l][0] <= hvd_pkg::CORDIC_GAIN;
        cy[l][0] <= '0;
        cz[l][0] <= c_neg[l] ? -$signed(CW'(c_q[l])) : $signed(CW'(c_q[l]));
        for (int i = 0; i < N; i++) begin
          if (cz[l][i] >= 0) begin
            cx[l][i+1] <= cx[l][i] - (cy[l][i] >>> i);
            cy[l][i+1] <= cy[l][i] + (cx[l][i] >>> i);
            cz[l][i+1] <= cz[l][i] - hvd_pkg::atan_entry(i);
          end else begin
            cx[l][i+1] <= cx[l][i] + (cy[l][i] >>> i);
            cy[l][i+1] <= cy[l][i] - (cx[l][i] >>> i);
            cz[l][i+1] <= cz[l][i] + hvd_pkg::atan_entry(i);
          end
        end
      end
    end
  end

  // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2), each product registered and rounded.
  always_ff @(posedge clk) begin
    if (adv) begin
      k_sin1 <= abs_sin(cy[hvd_pkg::LANE_DLAT][N]);
      k_sin2 <= abs_sin(cy[hvd_pkg::LANE_DLON][N]);
      k_cos1 <= clamp_cos(cx[hvd_pkg::LANE_LAT1][N]);
      k_cos2 <= clamp_cos(cx[hvd_pkg::LANE_LAT2][N]);
      p_cc   <= PW'(k_cos1) * PW'(k_cos2);
      p_s1   <= PW'(k_sin1) * PW'(k_sin1);
      p_s2   <= PW'(k_sin2) * PW'(k_sin2);
      r_cc   <= round_q30(p_cc);
      r_s1   <= round_q30(p_s1);
      r_s2   <= round_q30(p_s2);
      p_t    <= PW'(r_cc) * PW'(r_s2);
      h_s1   <= r_s1;
      r_t    <= round_q30(p_t);
      h2_s1  <= h_s1;
      if ((QW + 1)'(h2_s1) + (QW + 1)'(r_t) > (QW + 1)'(hvd_pkg::ONE_Q30)) begin
        hav_a <= hvd_pkg::ONE_Q30;
      end else begin
        hav_a <= h2_s1 + r_t;
      end
    end
  end

  // Square roots of a and 1 - a in Q30, one root bit per stage.
  always_ff @(posedge clk) begin
    if (adv) begin
      s_rem[0][0]  <= 64'(hav_a) << 30;
      s_rem[1][0]  <= 64'(hvd_pkg::ONE_Q30 - hav_a) << 30;
      for (int n = 0; n < 2; n++) begin
        s_root[n][0] <= '0;
        for (int j = 0; j < RB; j++) begin
          if (s_rem[n][j] >= ((64'(s_root[n][j]) << (RB - j))
                              + (64'd1 << (2 * (RB - 1 - j))))) begin
            s_rem[n][j+1]  <= s_rem[n][j] - ((64'(s_root[n][j]) << (RB - j))
                              + (64'd1 << (2 * (RB - 1 - j))));
            s_root[n][j+1] <= s_root[n][j] | (RB'(1) << (RB - 1 - j));
          end else begin
            s_rem[n][j+1]  <= s_rem[n][j];
            s_root[n][j+1] <= s_root[n][j];
          end
        end
      end
    end
  end

  // Vectoring CORDIC for atan2(sqrt(a), sqrt(1 - a)), then scaling by the radius.
  always_ff @(posedge clk) begin
    if (adv) begin
      vx[0] <= $signed(CW'(s_root[1][RB]));
      vy[0] <= $signed(CW'(s_root[0][RB]));
      vz[0] <= '0;
      for (int i = 0; i < N; i++) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + hvd_pkg::atan_entry(i);
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - hvd_pkg::atan_entry(i);
        end
      end
      if (vz[N] < 0) begin
        theta <= '0;
      end else if (vz[N] > $signed(CW'(hvd_pkg::HALF_PI_Q30))) begin
        theta <= hvd_pkg::HALF_PI_Q30;
      end else begin
        theta <= vz[N][QW-1:0];
      end
      f_prod <= PW'(radius_x200) * PW'(theta);
      if (f_sum[PW:30] > (PW - 29)'(hvd_pkg::DIST_MAX)) begin
        distance_cm <= hvd_pkg::DIST_MAX;
      end else begin
        distance_cm <= f_sum[60:30];
      end
    end
  end

endmodule

FILE: design/haversine_distance.sv
// Top level of the haversine great-circle distance block: radius register,
// front end, queue and back-end pipeline. Uses hvd_pkg, hvd_front, hvd_queue, hvd_back.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one pair of points per transaction,
//   latitudes and longitudes in signed microdegrees. A transaction completes at a
//   rising edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall) carries distance_cm, the great-circle
//   distance in centimeters, one result per input transaction, in order.
//   cfg_write_enable / cfg_write_data load the sphere radius in meters; write it
//   only while no transaction is in flight.
// Throughput: one pair per cycle, sustained while out_stall stays low.
// Pipeline from input to output: two front stages, one queue stage, a five-stage
//   degree-to-radian conversion, the bit-serial square root, the two CORDIC
//   chains of CORDIC_STEPS stages and the arithmetic around them.
// Reset (rst, synchronous) empties the pipeline and the queue and sets the
//   radius to 6371000 m.
// When the receiver stalls, the finished result is held and the back end halts;
//   the front end keeps taking transactions until the four-entry queue fills,
//   and only then raises in_stall.
module haversine_distance (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [hvd_pkg::LAT_W-1:0]     first_latitude,
  input  logic signed [hvd_pkg::LAT_W-1:0]     second_latitude,
  input  logic signed [hvd_pkg::LON_W-1:0]     first_longitude,
  input  logic signed [hvd_pkg::LON_W-1:0]     second_longitude,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hvd_pkg::DIST_W-1:0]           distance_cm,
  input  logic                                 cfg_write_enable,
  input  logic [hvd_pkg::RADIUS_W-1:0]         cfg_write_data
);

  logic [hvd_pkg::R200_W-1:0] radius_x200;
  hvd_pkg::queue_flags_t      flags;
  hvd_pkg::angle_set_t        front_item;
  hvd_pkg::angle_set_t        head;
  logic                       push;
  logic                       pop;

  // The radius is kept pre-scaled by 200 (meters to centimeters, times two).
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_x200 <= hvd_pkg::R200_RESET;
    end else if (cfg_write_enable) begin
      radius_x200 <= hvd_pkg::R200_W'(cfg_write_data) * hvd_pkg::R200_SCALE;
    end
  end

  hvd_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .first_latitude   (first_latitude),
    .second_latitude  (second_latitude),
    .first_longitude  (first_longitude),
    .second_longitude (second_longitude),
    .flags            (flags),
    .push             (push),
    .item             (front_item)
  );

  hvd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .item_in (front_item),
    .pop     (pop),
    .head    (head),
    .flags   (flags)
  );

  hvd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .flags       (flags),
    .pop         (pop),
    .radius_x200 (radius_x200),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .distance_cm (distance_cm)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the haversine distance block: pairs of points
// go in, distances are predicted by a fixed-point CORDIC model and compared.
// Depends on hvd_pkg and the haversine_distance RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = hvd_pkg::CORDIC_STEPS;
  localparam int DRAIN_CYCLES = 200;
  localparam longint PI_Q32_C = 64'd13493037705;
  localparam longint ONE_C = 64'd1073741824;
  localparam longint HALF_PI_C = 64'd1686629713;
  localparam longint GAIN_C = 64'd652032874;

  // Arctangent table in Q30.
  localparam longint ATAN_TBL [32] = '{
    'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
    'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
    'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
    'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
    'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002,
    'h00000001, 'h00000000};

  // Degrees to Q30 radians, rounded on the magnitude.
  function automatic longint to_rad(longint d, longint divisor);
    longint unsigned m, q;
    m = (d < 0) ? -d : d;
    q = (m * PI_Q32_C + divisor / 2) / divisor;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  // CORDIC rotation giving clamped cosine and sine.
  function automatic void rotate(input longint z, output longint c, output longint s);
    longint x, y, dx, dy;
    x = GAIN_C;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    c = (x < -ONE_C) ? -ONE_C : (x > ONE_C ? ONE_C : x);
    s = (y < -ONE_C) ? -ONE_C : (y > ONE_C ? ONE_C : y);
  endfunction

  // CORDIC vectoring giving the angle of (x, y).
  function automatic longint vector_angle(longint x, longint y);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned qmul(longint unsigned a, longint unsigned b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Great-circle distance in centimeters for one pair of points.
  function automatic logic [30:0] predict_distance(logic [22:0] radius,
      logic signed [27:0] la1, logic signed [27:0] la2,
      logic signed [28:0] lo1, logic signed [28:0] lo2);
    longint lat1, lat2, dlat, dlon, c1, s1, c2, s2, cl1, sl1, cl2, sl2, theta;
    longint unsigned cc, a, ra, rb, span;
    lat1 = la1;
    lat2 = la2;
    if (lat1 > 90000000) lat1 = 90000000;
    if (lat1 < -90000000) lat1 = -90000000;
    if (lat2 > 90000000) lat2 = 90000000;
    if (lat2 < -90000000) lat2 = -90000000;
    dlat = lat2 - lat1;
    dlon = (longint'(lo2) - longint'(lo1)) % 360000000;
    if (dlon > 180000000) dlon -= 360000000;
    if (dlon < -180000000) dlon += 360000000;
    rotate(to_rad(dlat, 1440000000), c1, s1);
    rotate(to_rad(dlon, 1440000000), c2, s2);
    rotate(to_rad(lat1, 720000000), cl1, sl1);
    rotate(to_rad(lat2, 720000000), cl2, sl2);
    if (cl1 < 0) cl1 = 0;
    if (cl2 < 0) cl2 = 0;
    if (s1 < 0) s1 = -s1;
    if (s2 < 0) s2 = -s2;
    cc = qmul(cl1, cl2);
    a = qmul(s1, s1) + qmul(cc, qmul(s2, s2));
    if (a > ONE_C) a = ONE_C;
    ra = int_sqrt(a << 30);
    rb = int_sqrt((ONE_C - a) << 30);
    theta = vector_angle(rb, ra);
    if (theta < 0) theta = 0;
    if (theta > HALF_PI_C) theta = HALF_PI_C;
    span = (longint'(radius) * 200 * theta + 64'd536870912) >> 30;
    if (span > 64'h7FFFFFFF) span = 64'h7FFFFFFF;
    return span[30:0];
  endfunction

  // Holds the expected distances in order and checks each result.
  class distance_board;
    logic [30:0] pending[$];
    int errors;
    int checked;

    function void note_pair(logic [22:0] radius, logic signed [27:0] la1,
        logic signed [27:0] la2, logic signed [28:0] lo1, logic signed [28:0] lo2);
      pending = {pending, predict_distance(radius, la1, la2, lo1, lo2)};
    endfunction

    function void check_distance(logic [30:0] got);
      logic [30:0] want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected distance %0d", $realtime, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got !== want) begin
        $display("%0t: distance_cm expected %0d actual %0d", $realtime, want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [27:0] first_latitude = '0;
  logic signed [27:0] second_latitude = '0;
  logic signed [28:0] first_longitude = '0;
  logic signed [28:0] second_longitude = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [30:0] distance_cm;
  logic cfg_write_enable = 1'b0;
  logic [22:0] cfg_write_data = '0;

  logic [22:0] radius_now = 23'd6371000;
  bit stall_quiet = 1'b0;
  int pairs_sent = 0;
  distance_board board = new();

  haversine_distance i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .first_latitude   (first_latitude),
    .second_latitude  (second_latitude),
    .first_longitude  (first_longitude),
    .second_longitude (second_longitude),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .distance_cm      (distance_cm),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, checking every accepted transaction.
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) board.check_distance(distance_cm);
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (!stall_quiet && $urandom_range(0, 9) == 0) begin
        hold = gap_len();
        out_stall <= (hold > 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Drives one pair and holds it until the block takes it.
  task automatic send_pair(logic signed [27:0] la1, logic signed [27:0] la2,
      logic signed [28:0] lo1, logic signed [28:0] lo2, bit allow_gap);
    int g;
    first_latitude <= la1;
    second_latitude <= la2;
    first_longitude <= lo1;
    second_longitude <= lo2;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    board.note_pair(radius_now, la1, la2, lo1, lo2);
    pairs_sent++;
    g = allow_gap ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Waits until every expected distance has come back, then lets the pipe settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(logic [22:0] r);
    cfg_write_enable <= 1'b1;
    cfg_write_data <= r;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    radius_now = r;
  endtask

  function automatic logic signed [27:0] rand_lat();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 28'($urandom());
    if (r == 1) return (r & 1) ? 28'sd90000000 : -28'sd90000000;
    return 28'($signed($urandom_range(0, 180000000)) - 90000000);
  endfunction

  function automatic logic signed [28:0] rand_lon();
    if ($urandom_range(0, 9) == 0) return 29'($urandom());
    return 29'($signed($urandom_range(0, 360000000)) - 180000000);
  endfunction

  // Random pairs, some close together to exercise small angles.
  task automatic random_pairs(int count);
    logic signed [27:0] la1, la2;
    logic signed [28:0] lo1, lo2;
    for (int n = 0; n < count; n++) begin
      la1 = rand_lat();
      lo1 = rand_lon();
      if ($urandom_range(0, 3) == 0) begin
        la2 = la1 + 28'($signed($urandom_range(0, 2000)) - 1000);
        lo2 = lo1 + 29'($signed($urandom_range(0, 2000)) - 1000);
      end else begin
        la2 = rand_lat();
        lo2 = rand_lon();
      end
      if (n % 200 < 30) stall_quiet = 1'b1;
      else stall_quiet = 1'b0;
      send_pair(la1, la2, lo1, lo2, n % 200 >= 30);
    end
    stall_quiet = 1'b0;
  endtask

  // Stimulus: directed corners, then random phases at several radii.
  initial begin
    logic [22:0] radii [5];
    radii = '{23'd6000000, 23'd6500000, 23'h7FFFFF, 23'd0, 23'd6371000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identical points, antipodes, poles, clamping and longitude wrap.
    send_pair(0, 0, 0, 0, 0);
    send_pair(28'sd90000000, -28'sd90000000, 0, 0, 0);
    send_pair(0, 0, -29'sd180000000, 29'sd180000000, 0);
    send_pair(0, 0, 0, 29'sd180000000, 0);
    send_pair(28'sh7FFFFFF, 28'sh8000000, 29'sh0FFFFFFF, 29'sh10000000, 0);
    send_pair(28'sh8000000, 28'sh7FFFFFF, 29'sh10000000, 29'sh0FFFFFFF, 0);
    send_pair(28'sd90000000, 28'sd90000000, -29'sd180000000, 29'sd179999999, 0);
    send_pair(-28'sd90000000, -28'sd89999999, 29'sd5, -29'sd5, 0);
    send_pair(28'sd45000000, -28'sd45000000, 29'sd170000000, -29'sd170000000, 0);
    send_pair(28'sd1, 28'sd0, 29'sd0, 29'sd1, 0);
    send_pair(-28'sd1, 28'sd1, -29'sd1, 29'sd1, 1);
    send_pair(28'sd48856600, 28'sd51507400, 29'sd2352200, -29'sd127800, 1);
    send_pair(28'sd0, 28'sd0, -29'sd179999999, 29'sd179999999, 1);
    send_pair(28'sd89999999, -28'sd89999999, 29'sd90000000, -29'sd90000000, 1);
    random_pairs(300);
    drain();

    // Each radius setting gets a random phase; the extremes saturate or zero out.
    foreach (radii[k]) begin
      write_radius(radii[k]);
      send_pair(28'sd90000000, -28'sd90000000, 0, 0, 0);
      random_pairs(k == 4 ? 400 : 180);
      drain();
    end

    $display("tb: %0d pairs sent, %0d distances checked over %0d radius settings",
      pairs_sent, board.checked, 6);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("tb: errors");
    $finish;
  end
endmodule

FILE: files.f
design/hvd_pkg.sv
design/hvd_front.sv
design/hvd_queue.sv
design/hvd_back.sv
design/haversine_distance.sv
verif/tb.sv
